/* rtl/lsep_pkg.sv */
// shared widths and character codes for the literal sum expression parser
package lsep_pkg;

    localparam int CHAR_BITS = 8;
    localparam int SUM_BITS  = 16;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [SUM_BITS-1:0]  sum_t;

    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_QUOTE = 8'h27;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;
    localparam char_t CH_SEVEN = 8'h37;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_LOW_A = 8'h61;
    localparam char_t CH_LOW_F = 8'h66;
    localparam char_t CH_LOW_X = 8'h78;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;

endpackage

/* rtl/lsep_if.sv */
// request channels: expression bytes in, sum and error flag out

interface lsep_in_if;
    logic                valid;
    logic                ready;
    lsep_pkg::char_t     char_byte;
    logic                last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface lsep_out_if;
    logic                valid;
    logic                ready;
    lsep_pkg::sum_t      sum_value;
    logic                syntax_error;

    modport source (output valid, output sum_value, output syntax_error, input ready);
    modport sink   (input valid, input sum_value, input syntax_error, output ready);
endinterface

/* rtl/literal_sum_expression_parser.sv */
// literal sum expression parser: one byte per cycle while the skid entry is empty
// throughput: one byte accepted per cycle while the skid entry is empty
// a last byte's result goes to the result register, or to the skid entry if a held result stalls
// a two-entry output (result register plus skid register) lets bytes flow while a result waits
// reset (rst_n low, asynchronous) clears the sum, term, phase, error flag and both output entries
module literal_sum_expression_parser #(
    parameter int WORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lsep_in_if.sink     in_chan,
    lsep_out_if.source  out_chan
);
    import lsep_pkg::*;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGNED,
        PH_DEC,
        PH_ZERO,
        PH_OCT,
        PH_HEX0,
        PH_HEX,
        PH_QOPEN,
        PH_QCHAR,
        PH_DONE
    } phase_t;

    typedef struct packed {
        sum_t sum_value;
        logic syntax_error;
    } result_t;

    // parser state
    word_t   sum_reg,   sum_next;
    word_t   term_reg,  term_next;
    logic    neg_reg,   neg_next;
    phase_t  phase_reg, phase_next;
    logic    err_reg,   err_next;

    // output entries
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    accept;
    logic    out_fire;
    char_t   c;
    logic    is_space;
    logic    is_sign;
    logic    do_add;
    word_t   term_dig;
    word_t   sum_added;
    logic    push;
    result_t res;

    assign accept   = in_chan.valid && in_chan.ready;
    assign out_fire = out_valid_reg && out_chan.ready;
    assign c        = in_chan.char_byte;
    assign in_chan.ready = !skid_valid_reg;

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.sum_value    = out_reg.sum_value;
    assign out_chan.syntax_error = out_reg.syntax_error;

    assign is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);

    // term accumulator and phase update for one byte
    always_comb
    begin
        logic complete;
        term_dig   = term_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        do_add     = 1'b0;
        complete   = (phase_reg == PH_DEC) || (phase_reg == PH_ZERO) ||
                     (phase_reg == PH_OCT) || (phase_reg == PH_HEX) ||
                     (phase_reg == PH_DONE);
        if (phase_reg == PH_QOPEN)
        begin
            term_dig   = word_t'(c);
            phase_next = PH_QCHAR;
        end
        else if (phase_reg == PH_QCHAR)
        begin
            if (c == CH_QUOTE)
                phase_next = PH_DONE;
            else
                err_next = 1'b1;
        end
        else if (is_space)
        begin
            // whitespace is skipped outside a char literal
        end
        else if (is_sign)
        begin
            if (phase_reg == PH_START)
            begin
                neg_next   = (c == CH_MINUS);
                phase_next = PH_SIGNED;
            end
            else if (complete)
            begin
                do_add     = 1'b1;
                neg_next   = (c == CH_MINUS);
                phase_next = PH_SIGNED;
            end
            else
                err_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_START, PH_SIGNED:
                begin
                    if (c inside {[CH_ONE:CH_NINE]})
                    begin
                        term_dig   = word_t'(c - CH_ZERO);
                        phase_next = PH_DEC;
                    end
                    else if (c == CH_ZERO)
                    begin
                        term_dig   = '0;
                        phase_next = PH_ZERO;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        term_dig   = '0;
                        phase_next = PH_QOPEN;
                    end
                    else
                    begin
                        term_dig = '0;
                        err_next = 1'b1;
                    end
                end
                PH_DEC:
                begin
                    if (c inside {[CH_ZERO:CH_NINE]})
                        term_dig = (term_reg << 3) + (term_reg << 1) +
                                   word_t'(c - CH_ZERO);
                    else
                        err_next = 1'b1;
                end
                PH_ZERO, PH_OCT:
                begin
                    if (c == CH_LOW_X && phase_reg == PH_ZERO)
                        phase_next = PH_HEX0;
                    else if (c inside {[CH_ZERO:CH_SEVEN]})
                    begin
                        term_dig   = (term_reg << 3) + word_t'(c - CH_ZERO);
                        phase_next = PH_OCT;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_HEX0, PH_HEX:
                begin
                    if (c inside {[CH_ZERO:CH_NINE]})
                    begin
                        term_dig   = (term_reg << 4) + word_t'(c - CH_ZERO);
                        phase_next = PH_HEX;
                    end
                    else if (c inside {[CH_LOW_A:CH_LOW_F]})
                    begin
                        term_dig   = (term_reg << 4) + word_t'(c - CH_LOW_A + 8'd10);
                        phase_next = PH_HEX;
                    end
                    else
                        err_next = 1'b1;
                end
                default:
                    err_next = 1'b1;
            endcase
        end

        // end of text: fold in a finished term, else flag it
        if (in_chan.last_byte && !do_add)
        begin
            if ((phase_next == PH_DEC) || (phase_next == PH_ZERO) ||
                (phase_next == PH_OCT) || (phase_next == PH_HEX) ||
                (phase_next == PH_DONE))
                do_add = 1'b1;
            else
                err_next = 1'b1;
        end
        else if (in_chan.last_byte)
            err_next = 1'b1;
    end

    // single adder shared by sign and end of text
    assign sum_added = neg_reg ? (sum_reg - term_dig) : (sum_reg + term_dig);
    assign sum_next  = do_add ? sum_added : sum_reg;
    assign term_next = do_add ? '0 : term_dig;

    assign push          = accept && in_chan.last_byte;
    assign res.sum_value = SUM_BITS'(sum_next);
    assign res.syntax_error = err_next;

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            term_reg  <= '0;
            neg_reg   <= 1'b0;
            phase_reg <= PH_START;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (in_chan.last_byte)
            begin
                sum_reg   <= '0;
                term_reg  <= '0;
                neg_reg   <= 1'b0;
                phase_reg <= PH_START;
                err_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                term_reg  <= term_next;
                neg_reg   <= neg_next;
                phase_reg <= phase_next;
                err_reg   <= err_next;
            end
        end
    end

    // result register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            skid_valid_reg <= 1'b0;
            skid_reg       <= '0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // a stalled skid entry is kept
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_chan.ready |=> skid_valid_reg)
        else $error("skid entry lost while output stalled");

    // end of text returns the parser to its reset state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_chan.last_byte |=>
            phase_reg == PH_START && sum_reg == '0 && term_reg == '0 && !err_reg)
        else $error("parser state not cleared after last byte");

    // error flag is sticky within one expression
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_chan.last_byte && err_reg |=> err_reg)
        else $error("error flag dropped mid expression");

endmodule
